>>> rtl/core/eeprom_controller_registers_assert.svh
// Assertion helpers shared by the eeprom controller RTL.
// Each macro expands to one labeled concurrent assertion, reset gated.
`ifndef EEPROM_CONTROLLER_REGISTERS_ASSERT_SVH
`define EEPROM_CONTROLLER_REGISTERS_ASSERT_SVH

// Same-cycle implication.
`define ECR_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define ECR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/ecr_pkg.sv
// ----------------------------------------------------------------------------
// ecr_pkg
// Types, register map and helper functions of the eeprom controller block.
// ----------------------------------------------------------------------------
`default_nettype none

package ecr_pkg;

    localparam int STORE_BYTES_DEF = 4096;

    localparam logic [11:0] REG_BASE = 12'h080;

    // register offsets relative to REG_BASE
    localparam logic [11:0] RG_CMD       = 12'h000;
    localparam logic [11:0] RG_ADDR      = 12'h004;
    localparam logic [11:0] RG_WDATA     = 12'h008;
    localparam logic [11:0] RG_RDATA     = 12'h00C;
    localparam logic [11:0] RG_WAIT      = 12'h010;
    localparam logic [11:0] RG_CLKDIV    = 12'h014;
    localparam logic [11:0] RG_PWRDN     = 12'h018;
    localparam logic [11:0] RG_IEN_CLR   = 12'hF58;
    localparam logic [11:0] RG_IEN_SET   = 12'hF5C;
    localparam logic [11:0] RG_ISTAT     = 12'hF60;
    localparam logic [11:0] RG_IEN      = 12'hF64;
    localparam logic [11:0] RG_ISTAT_CLR = 12'hF68;
    localparam logic [11:0] RG_ISTAT_SET = 12'hF6C;

    localparam logic [31:0] ST_END_RW   = 32'h0400_0000;
    localparam logic [31:0] ST_END_PROG = 32'h1000_0000;
    localparam logic [2:0]  CMD_PROGRAM = 3'd6;
    localparam logic [7:0]  ERASED      = 8'hFF;

    typedef struct packed {
        logic        mode;
        logic [11:0] offset;
        logic [2:0]  access_bytes;
        logic [31:0] write_data;
    } req_t;

    typedef struct packed {
        logic [31:0] read_data;
        logic [31:0] interrupt_status;
    } rsp_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC,
        ST_RESP
    } state_t;

    typedef struct packed {
        logic clear;
        logic capture;
        logic exec;
        logic respond;
    } ctrl_t;

    typedef struct packed {
        logic clear_last;
    } stat_t;

    function automatic logic [31:0] lane_mask(input logic [2:0] n);
        logic [31:0] m;
        case (n)
            3'd1:    m = 32'h0000_00FF;
            3'd2:    m = 32'h0000_FFFF;
            3'd3:    m = 32'h00FF_FFFF;
            default: m = 32'hFFFF_FFFF;
        endcase
        return m;
    endfunction

    // bytes moved by a data register access, from command bits 2:0
    function automatic logic [2:0] data_width(input logic [2:0] cmd);
        logic [2:0] w;
        case (cmd)
            3'd1, 3'd4: w = 3'd2;
            3'd2, 3'd5: w = 3'd4;
            default:    w = 3'd1;
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/ecr_bank.sv
// ----------------------------------------------------------------------------
// ecr_bank
// One byte lane of the store: single port RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module ecr_bank #(
    parameter int ROWS = 1024
) (
    input  wire logic                    clk,
    input  wire logic                    we,
    input  wire logic [$clog2(ROWS)-1:0] addr,
    input  wire logic [7:0]              wdata,
    output logic      [7:0]              rdata
);

    logic [7:0] mem [ROWS];
    logic [7:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

>>> rtl/core/ecr_ctrl.sv
// ----------------------------------------------------------------------------
// ecr_ctrl
// Sequencer: store clearing pass after reset, then accept, execute, respond.
// ----------------------------------------------------------------------------
`default_nettype none

module ecr_ctrl (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           start,
    input  wire ecr_pkg::stat_t stat,
    output logic                busy,
    output logic                done,
    output ecr_pkg::ctrl_t      ctrl
);
    import ecr_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (stat.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: state_next = ST_RESP;
            ST_RESP: state_next = ST_IDLE;
            default: state_next = ST_CLEAR;
        endcase
    end

    always_comb
    begin
        busy         = 1'b1;
        done         = 1'b0;
        ctrl         = '0;
        case (state_reg)
            ST_CLEAR: ctrl.clear = 1'b1;
            ST_IDLE:
            begin
                busy         = 1'b0;
                ctrl.capture = start;
            end
            ST_EXEC: ctrl.exec = 1'b1;
            ST_RESP:
            begin
                ctrl.respond = 1'b1;
                done         = 1'b1;
            end
            default: ctrl.clear = 1'b1;
        endcase
    end

`include "eeprom_controller_registers_assert.svh"

    `ECR_ASSERT_NOW(a_one_step, clk, rst_n, 1'b1, $onehot0(ctrl), "control steps overlap")
    `ECR_ASSERT_NEXT(a_accept_exec, clk, rst_n, start && !busy, busy && !done, "accept not followed by execute")
    `ECR_ASSERT_NOW(a_done_latency, clk, rst_n, done, $past(start && !busy, 2), "result without an accept two cycles before")
    `ECR_ASSERT_NEXT(a_done_frees, clk, rst_n, done, !busy && !done, "controller not idle after a result")

endmodule

`default_nettype wire

>>> rtl/core/ecr_datapath.sv
// ----------------------------------------------------------------------------
// ecr_datapath
// Register file, address decode and the four byte-lane banks of the store.
// ----------------------------------------------------------------------------
`default_nettype none

module ecr_datapath #(
    parameter int STORE_BYTES = ecr_pkg::STORE_BYTES_DEF
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire ecr_pkg::ctrl_t ctrl,
    input  wire ecr_pkg::req_t  req,
    output ecr_pkg::stat_t      stat,
    output ecr_pkg::rsp_t       rsp
);
    import ecr_pkg::*;

    localparam int ROWS   = STORE_BYTES / 4;
    localparam int ROW_W  = $clog2(ROWS);
    localparam int ADDR_W = $clog2(STORE_BYTES);
    localparam int BASE_W = ADDR_W + 1;

    req_t        req_reg;
    logic [31:0] cmd_reg,    cmd_next;
    logic [11:0] waddr_reg,  waddr_next;
    logic [31:0] wait_reg,   wait_next;
    logic [31:0] clkdiv_reg, clkdiv_next;
    logic        pwrdn_reg,  pwrdn_next;
    logic [31:0] ien_reg,    ien_next;
    logic [31:0] istat_reg,  istat_next;
    logic [ROW_W-1:0] clr_cnt_reg;

    // response side, captured at execute
    logic [31:0] rd_val_reg;
    logic        sel_mem_reg;
    logic [31:0] mask_reg;
    logic [1:0]  base_lo_reg;
    logic [3:0]  lane_en_reg;

    logic [2:0]  n;
    logic [31:0] mask;
    logic [31:0] v;
    logic        is_direct;
    logic        is_wr;
    logic [11:0] diff;
    logic [11:0] rsel;
    logic [2:0]  width;
    logic        data_acc;
    logic [31:0] rd_val;
    logic [BASE_W-1:0] base;
    logic [2:0]  cnt;
    logic        mem_wr;

    logic [1:0]        lane_i    [4];
    logic [BASE_W-1:0] lane_addr [4];
    logic [ROW_W-1:0]  lane_row  [4];
    logic [7:0]        lane_wdata[4];
    logic [3:0]        lane_en;

    logic              bank_we   [4];
    logic [ROW_W-1:0]  bank_addr [4];
    logic [7:0]        bank_wdata[4];
    logic [7:0]        bank_rdata[4];

    logic [31:0] gather;
    logic [1:0]  glane;

    always_comb
    begin
        n = req_reg.access_bytes;
        if (n == 3'd0)
        begin
            n = 3'd1;
        end
        else if (n > 3'd4)
        begin
            n = 3'd4;
        end
        mask      = lane_mask(n);
        v         = req_reg.write_data & mask;
        is_wr     = req_reg.mode;
        is_direct = req_reg.offset < REG_BASE;
        diff      = req_reg.offset - REG_BASE;
        rsel      = diff & 12'hFFC;
        width     = data_width(cmd_reg[2:0]);
        data_acc  = !is_direct && ((is_wr && rsel == RG_WDATA) || (!is_wr && rsel == RG_RDATA));

        cmd_next    = cmd_reg;
        waddr_next  = waddr_reg;
        wait_next   = wait_reg;
        clkdiv_next = clkdiv_reg;
        pwrdn_next  = pwrdn_reg;
        ien_next    = ien_reg;
        istat_next  = istat_reg;
        rd_val      = '0;

        if (!is_direct && is_wr)
        begin
            case (rsel)
                RG_CMD:
                begin
                    cmd_next = v;
                    if (v[2:0] == CMD_PROGRAM)
                    begin
                        istat_next = istat_reg | ST_END_PROG | ST_END_RW;
                    end
                end
                RG_ADDR:      waddr_next  = v[11:0];
                RG_WAIT:      wait_next   = v;
                RG_CLKDIV:    clkdiv_next = v;
                RG_PWRDN:     pwrdn_next  = v[0];
                RG_IEN_CLR:   ien_next    = ien_reg & ~v;
                RG_IEN_SET:   ien_next    = ien_reg | v;
                RG_ISTAT_CLR: istat_next  = istat_reg & ~v;
                RG_ISTAT_SET: istat_next  = istat_reg | v;
                default:      ;
            endcase
        end
        else if (!is_direct)
        begin
            case (rsel)
                RG_CMD:    rd_val = cmd_reg;
                RG_ADDR:   rd_val = {20'd0, waddr_reg};
                RG_WAIT:   rd_val = wait_reg;
                RG_CLKDIV: rd_val = clkdiv_reg;
                RG_PWRDN:  rd_val = {31'd0, pwrdn_reg};
                RG_ISTAT:  rd_val = istat_reg;
                RG_IEN:    rd_val = ien_reg;
                default:   rd_val = '0;
            endcase
        end

        if (data_acc)
        begin
            waddr_next = waddr_reg + {9'd0, width};
            istat_next = istat_reg | ST_END_RW;
        end

        base   = is_direct ? BASE_W'(req_reg.offset[6:0])
                           : BASE_W'(waddr_reg[ADDR_W-1:0]);
        cnt    = is_direct ? n : width;
        mem_wr = is_wr && (is_direct || data_acc);
    end

    // each lane takes the one byte of the access that falls in it
    always_comb
    begin
        for (int l = 0; l < 4; l++)
        begin
            lane_i[l]     = 2'(l) - base[1:0];
            lane_addr[l]  = base + BASE_W'(lane_i[l]);
            lane_row[l]   = lane_addr[l][ADDR_W-1:2];
            lane_wdata[l] = v[8*lane_i[l] +: 8];
            lane_en[l]    = ({1'b0, lane_i[l]} < cnt) && !lane_addr[l][ADDR_W]
                            && (is_direct || data_acc);
            bank_we[l]    = ctrl.clear || (ctrl.exec && mem_wr && lane_en[l]);
            bank_addr[l]  = ctrl.clear ? clr_cnt_reg : lane_row[l];
            bank_wdata[l] = ctrl.clear ? ERASED : lane_wdata[l];
        end
    end

    for (genvar g = 0; g < 4; g++)
    begin : g_bank
        ecr_bank #(
            .ROWS (ROWS)
        ) u_bank (
            .clk   (clk),
            .we    (bank_we[g]),
            .addr  (bank_addr[g]),
            .wdata (bank_wdata[g]),
            .rdata (bank_rdata[g])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_reg     <= '0;
            waddr_reg   <= '0;
            wait_reg    <= '0;
            clkdiv_reg  <= '0;
            pwrdn_reg   <= 1'b0;
            ien_reg     <= '0;
            istat_reg   <= '0;
            clr_cnt_reg <= '0;
        end
        else
        begin
            if (ctrl.clear)
            begin
                clr_cnt_reg <= clr_cnt_reg + ROW_W'(1);
            end
            if (ctrl.exec)
            begin
                cmd_reg    <= cmd_next;
                waddr_reg  <= waddr_next;
                wait_reg   <= wait_next;
                clkdiv_reg <= clkdiv_next;
                pwrdn_reg  <= pwrdn_next;
                ien_reg    <= ien_next;
                istat_reg  <= istat_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.capture)
        begin
            req_reg <= req;
        end
        if (ctrl.exec)
        begin
            rd_val_reg  <= rd_val & mask;
            sel_mem_reg <= !is_wr && (is_direct || data_acc);
            mask_reg    <= mask;
            base_lo_reg <= base[1:0];
            lane_en_reg <= lane_en;
        end
    end

    // byte i of the read comes from lane base+i; lanes past the store read zero
    always_comb
    begin
        gather = '0;
        glane  = '0;
        for (int i = 0; i < 4; i++)
        begin
            glane = base_lo_reg + 2'(i);
            gather[8*i +: 8] = lane_en_reg[glane] ? bank_rdata[glane] : 8'd0;
        end
    end

    assign stat.clear_last = (clr_cnt_reg == ROW_W'(ROWS - 1));

    assign rsp.read_data        = req_reg.mode ? 32'd0
                                : (sel_mem_reg ? (gather & mask_reg) : rd_val_reg);
    assign rsp.interrupt_status = istat_reg;

endmodule

`default_nettype wire

>>> rtl/core/eeprom_controller_registers.sv
// ----------------------------------------------------------------------------
// eeprom_controller_registers
// Bus-side register and byte store model of an on-chip EEPROM controller.
// ----------------------------------------------------------------------------
// Usage:
//   A bus beat (mode, offset, access_bytes, write_data) is taken on request
//   at a rising edge where start is high and busy is low.
//   done rises after the execute step and stays high for exactly one cycle
//   with result (read_data, interrupt_status). The receiver cannot stall:
//   the result is gone after that cycle. Each beat passes through accept,
//   execute (register update, bank read/write issue) and respond (registered
//   bank read data), and busy is high through execute and respond, so a new
//   beat is taken only after done. The store is four byte-lane single-port
//   banks, so an unaligned 4-byte access finishes in one pass.
//   After reset every map register is zero and busy stays high while the
//   store is erased to 0xFF, one row of four bytes per cycle.
//   STORE_BYTES must be a power of two between 256 and 4096.
// ----------------------------------------------------------------------------
`default_nettype none

module eeprom_controller_registers #(
    parameter int STORE_BYTES = ecr_pkg::STORE_BYTES_DEF
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    input  wire ecr_pkg::req_t request,
    output logic               busy,
    output logic               done,
    output ecr_pkg::rsp_t      result
);
    import ecr_pkg::*;

    ctrl_t ctrl;
    stat_t stat;

    ecr_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .busy  (busy),
        .done  (done),
        .ctrl  (ctrl)
    );

    ecr_datapath #(
        .STORE_BYTES (STORE_BYTES)
    ) u_datapath (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (ctrl),
        .req   (request),
        .stat  (stat),
        .rsp   (result)
    );

endmodule

`default_nettype wire
